// File: hw/rtl/tpc_pkg.sv
// tpc_pkg: shared types and constants for the triangle plane clipper
// no dependencies; imported by every module of the clipper
`default_nettype none

package tpc_pkg;

    localparam int CW = 32;
    localparam int FB = 16;

    // distance width: difference (CW+1) times normal (CW), sum of three
    localparam int DW = 2 * CW + 3;
    // crossing fraction, 0 to 2^FB inclusive
    localparam int TW = FB + 1;

    // configuration register indexes
    localparam logic [2:0] REG_POINT_X  = 3'd0;
    localparam logic [2:0] REG_POINT_Y  = 3'd1;
    localparam logic [2:0] REG_POINT_Z  = 3'd2;
    localparam logic [2:0] REG_NORMAL_X = 3'd3;
    localparam logic [2:0] REG_NORMAL_Y = 3'd4;
    localparam logic [2:0] REG_NORMAL_Z = 3'd5;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } vec_t;

    typedef struct packed {
        coord_t vertex0_x;
        coord_t vertex0_y;
        coord_t vertex0_z;
        coord_t vertex1_x;
        coord_t vertex1_y;
        coord_t vertex1_z;
        coord_t vertex2_x;
        coord_t vertex2_y;
        coord_t vertex2_z;
    } tri_in_t;

    typedef struct packed {
        logic   side;
        logic   last;
        coord_t out0_x;
        coord_t out0_y;
        coord_t out0_z;
        coord_t out1_x;
        coord_t out1_y;
        coord_t out1_z;
        coord_t out2_x;
        coord_t out2_y;
        coord_t out2_z;
    } tri_out_t;

    typedef struct packed {
        vec_t point;
        vec_t normal;
    } plane_t;

endpackage

`default_nettype wire

// File: hw/rtl/tpc_divider.sv
// tpc_divider: pipelined restoring divider, one quotient bit per stage
// depends on tpc_pkg; computes floor(num * 2^FB / den) with num <= den
`default_nettype none

module tpc_divider
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic [tpc_pkg::DW-1:0] num,
    input  wire logic [tpc_pkg::DW-1:0] den,
    output logic                       out_valid,
    output logic [tpc_pkg::TW-1:0]     quot
);
    import tpc_pkg::*;

    localparam int NS = TW;

    logic [NS-1:0]       valid_reg;
    logic [DW:0]         rem_reg  [NS];
    logic [DW-1:0]       den_reg  [NS];
    logic [TW-1:0]       q_reg    [NS];

    // one trial subtract per stage; remainder stays below den
    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        logic          valid_in;
        logic [DW:0]   rem_in;
        logic [DW-1:0] den_in;
        logic [TW-1:0] q_in;
        logic [DW+1:0] trial;
        logic [DW:0]   rem_next;
        logic          bit_next;

        // stage 0 loads the operands, later stages chain
        if (s == 0)
        begin : g_load
            assign valid_in = in_valid;
            assign rem_in   = {1'b0, num};
            assign den_in   = den;
            assign q_in     = '0;
        end
        else
        begin : g_chain
            assign valid_in = valid_reg[s-1];
            assign rem_in   = rem_reg[s-1];
            assign den_in   = den_reg[s-1];
            assign q_in     = q_reg[s-1];
        end

        always_comb
        begin
            if (s == 0)
            begin
                // first quotient bit is num >= den (num <= den)
                trial    = {1'b0, rem_in} - {2'b00, den_in};
                bit_next = ~trial[DW+1];
                rem_next = bit_next ? trial[DW:0] : rem_in;
            end
            else
            begin
                trial    = {rem_in, 1'b0} - {2'b00, den_in};
                bit_next = ~trial[DW+1];
                rem_next = bit_next ? trial[DW:0] : {rem_in[DW-1:0], 1'b0};
            end
        end
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else
                valid_reg[s] <= valid_in;
        end
        always_ff @(posedge clk)
        begin
            rem_reg[s] <= rem_next;
            den_reg[s] <= den_in;
            q_reg[s]   <= {q_in[TW-2:0], bit_next};
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign quot      = q_reg[NS-1];

endmodule

`default_nettype wire

// File: hw/rtl/tpc_lerp.sv
// tpc_lerp: one-stage crossing point a + floor(t * (b - a) / 2^FB) per axis
// depends on tpc_pkg
`default_nettype none

module tpc_lerp
(
    input  wire logic               clk,
    input  wire tpc_pkg::vec_t      a,
    input  wire tpc_pkg::vec_t      b,
    input  wire logic [tpc_pkg::TW-1:0] t,
    output tpc_pkg::vec_t           res
);
    import tpc_pkg::*;

    localparam int PW = CW + 1 + TW + 1;

    coord_t                a_reg [3];
    logic signed [PW-1:0]  prod_reg [3];
    coord_t                ain [3];
    coord_t                bin [3];
    coord_t                r   [3];

    assign ain[0] = a.x;
    assign ain[1] = a.y;
    assign ain[2] = a.z;
    assign bin[0] = b.x;
    assign bin[1] = b.y;
    assign bin[2] = b.z;

    for (genvar k = 0; k < 3; k++)
    begin : g_axis
        logic signed [PW-1:0] sh;
        // product register
        always_ff @(posedge clk)
        begin
            a_reg[k]    <= ain[k];
            prod_reg[k] <= PW'($signed({bin[k][CW-1], bin[k]}) - $signed({ain[k][CW-1], ain[k]}))
                           * $signed({1'b0, t});
        end
        assign sh   = prod_reg[k] >>> FB;
        assign r[k] = a_reg[k] + sh[CW-1:0];
    end

    assign res.x = r[0];
    assign res.y = r[1];
    assign res.z = r[2];

endmodule

`default_nettype wire

// File: hw/rtl/triangle_plane_clipper.sv
// triangle_plane_clipper: top level, distance pipeline, dividers, lerps, output sequencer
// depends on tpc_pkg, tpc_divider, tpc_lerp
//
//  channel  | handshake                  | payload
//  request  | start / busy               | tri_in (tri_in_t)
//  result   | result_valid (one cycle)   | tri_out (tri_out_t)
//  config   | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// the result of a request passes the distance stages, dividers and lerps; a straddling triangle
// leaves three results, one a cycle, so busy is raised after every request, whole or split,
// and start is taken again only once busy has fallen.
// reset clears valid bits and sets the plane to (0,0,0) with normal (0,0,1.0).
// the receiver cannot stall.
`default_nettype none

module triangle_plane_clipper
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire tpc_pkg::tri_in_t   tri_in,
    output logic                    result_valid,
    output tpc_pkg::tri_out_t       tri_out,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);
    import tpc_pkg::*;

    typedef struct packed {
        logic      valid;
        logic      split;
        logic      lone_side;
        logic      whole_side;
        vec_t      v0;
        vec_t      v1;
        vec_t      v2;
    } ctl_t;

    plane_t plane_reg;
    logic   accept;
    logic [1:0] hold_reg;

    assign cfg_ready = 1'b1;
    assign busy      = hold_reg != 2'd0;
    assign accept    = start && !busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= '{point: '0, normal: '{x: '0, y: '0, z: coord_t'(1 << FB)}};
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_POINT_X:  plane_reg.point.x  <= cfg_data;
                REG_POINT_Y:  plane_reg.point.y  <= cfg_data;
                REG_POINT_Z:  plane_reg.point.z  <= cfg_data;
                REG_NORMAL_X: plane_reg.normal.x <= cfg_data;
                REG_NORMAL_Y: plane_reg.normal.y <= cfg_data;
                REG_NORMAL_Z: plane_reg.normal.z <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1: differences
    vec_t in_v [3];
    assign in_v[0] = '{tri_in.vertex0_x, tri_in.vertex0_y, tri_in.vertex0_z};
    assign in_v[1] = '{tri_in.vertex1_x, tri_in.vertex1_y, tri_in.vertex1_z};
    assign in_v[2] = '{tri_in.vertex2_x, tri_in.vertex2_y, tri_in.vertex2_z};

    logic                 s1_valid_reg;
    vec_t                 s1_v_reg [3];
    logic signed [CW:0]   s1_diff_reg [3][3];
    logic signed [2*CW:0] s2_prod_reg [3][3];
    logic                 s2_valid_reg;
    vec_t                 s2_v_reg [3];
    logic signed [DW-1:0] s3_d_reg [3];
    logic                 s3_valid_reg;
    vec_t                 s3_v_reg [3];

    coord_t pp [3];
    coord_t nn [3];
    assign pp[0] = plane_reg.point.x;
    assign pp[1] = plane_reg.point.y;
    assign pp[2] = plane_reg.point.z;
    assign nn[0] = plane_reg.normal.x;
    assign nn[1] = plane_reg.normal.y;
    assign nn[2] = plane_reg.normal.z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_vert
        coord_t vc [3];
        assign vc[0] = in_v[k].x;
        assign vc[1] = in_v[k].y;
        assign vc[2] = in_v[k].z;
        for (genvar j = 0; j < 3; j++)
        begin : g_ax
            // stage 1 difference, stage 2 product
            always_ff @(posedge clk)
            begin
                s1_diff_reg[k][j] <= $signed({vc[j][CW-1], vc[j]})
                                     - $signed({pp[j][CW-1], pp[j]});
                s2_prod_reg[k][j] <= s1_diff_reg[k][j] * nn[j];
            end
        end
        // stage 3 sum
        always_ff @(posedge clk)
        begin
            s1_v_reg[k] <= in_v[k];
            s2_v_reg[k] <= s1_v_reg[k];
            s3_v_reg[k] <= s2_v_reg[k];
            s3_d_reg[k] <= DW'(s2_prod_reg[k][0]) + DW'(s2_prod_reg[k][1])
                           + DW'(s2_prod_reg[k][2]);
        end
    end

    // stage 4: classify, rotate, magnitudes
    logic [2:0] up;
    logic [1:0] n_up;
    logic [1:0] lone;
    logic       split;
    always_comb
    begin
        for (int k = 0; k < 3; k++)
            up[k] = ~s3_d_reg[k][DW-1];
        n_up  = 2'(up[0]) + 2'(up[1]) + 2'(up[2]);
        split = (n_up == 2'd1) || (n_up == 2'd2);
        lone  = 2'd0;
        for (int k = 2; k >= 0; k--)
            if (up[k] == (n_up == 2'd1))
                lone = 2'(k);
    end

    logic [DW-1:0] mag [3];
    for (genvar k = 0; k < 3; k++)
    begin : g_mag
        assign mag[k] = s3_d_reg[k][DW-1] ? DW'(-s3_d_reg[k]) : DW'(s3_d_reg[k]);
    end

    ctl_t          s4_ctl_reg;
    logic [DW-1:0] s4_m0_reg, s4_m1_reg, s4_m2_reg;
    logic          s4_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s4_ctl_reg.valid      <= s3_valid_reg;
        s4_ctl_reg.split      <= split;
        s4_ctl_reg.lone_side  <= n_up == 2'd1;
        s4_ctl_reg.whole_side <= n_up == 2'd3;
        unique case (lone)
            2'd1:
            begin
                s4_ctl_reg.v0 <= s3_v_reg[1];
                s4_ctl_reg.v1 <= s3_v_reg[2];
                s4_ctl_reg.v2 <= s3_v_reg[0];
                s4_m0_reg <= mag[1]; s4_m1_reg <= mag[2]; s4_m2_reg <= mag[0];
            end
            2'd2:
            begin
                s4_ctl_reg.v0 <= s3_v_reg[2];
                s4_ctl_reg.v1 <= s3_v_reg[0];
                s4_ctl_reg.v2 <= s3_v_reg[1];
                s4_m0_reg <= mag[2]; s4_m1_reg <= mag[0]; s4_m2_reg <= mag[1];
            end
            default:
            begin
                s4_ctl_reg.v0 <= s3_v_reg[0];
                s4_ctl_reg.v1 <= s3_v_reg[1];
                s4_ctl_reg.v2 <= s3_v_reg[2];
                s4_m0_reg <= mag[0]; s4_m1_reg <= mag[1]; s4_m2_reg <= mag[2];
            end
        endcase
    end

    // stage 5: divisor sums
    logic [DW-1:0] s5_m0_reg, s5_den1_reg, s5_den2_reg;
    ctl_t          s5_ctl_reg;
    logic          s5_valid_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else
            s5_valid_reg <= s4_valid_reg;
    end
    always_ff @(posedge clk)
    begin
        s5_ctl_reg  <= s4_ctl_reg;
        s5_m0_reg   <= s4_m0_reg;
        s5_den1_reg <= s4_m0_reg + s4_m1_reg;
        s5_den2_reg <= s4_m0_reg + s4_m2_reg;
    end

    // fraction dividers, control delayed alongside
    logic          dv1, dv2;
    logic [TW-1:0] t1, t2;
    tpc_divider u_div1 (.clk, .rst_n, .in_valid(s5_valid_reg), .num(s5_m0_reg),
                        .den(s5_den1_reg), .out_valid(dv1), .quot(t1));
    tpc_divider u_div2 (.clk, .rst_n, .in_valid(s5_valid_reg), .num(s5_m0_reg),
                        .den(s5_den2_reg), .out_valid(dv2), .quot(t2));

    ctl_t ctl_dly_reg [TW+1];
    always_ff @(posedge clk)
    begin
        ctl_dly_reg[0] <= s5_ctl_reg;
        for (int i = 1; i < TW + 1; i++)
            ctl_dly_reg[i] <= ctl_dly_reg[i-1];
    end

    // crossing points, one register stage
    vec_t i1, i2;
    tpc_lerp u_lerp1 (.clk, .a(ctl_dly_reg[TW-1].v0), .b(ctl_dly_reg[TW-1].v1),
                      .t(t1), .res(i1));
    tpc_lerp u_lerp2 (.clk, .a(ctl_dly_reg[TW-1].v0), .b(ctl_dly_reg[TW-1].v2),
                      .t(t2), .res(i2));

    logic dv_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg <= 1'b0;
        else
            dv_reg <= dv1;
    end

    // output sequencer
    ctl_t       fin;
    logic [1:0] seq_reg;
    ctl_t       hc_reg;
    vec_t       hi1_reg, hi2_reg;
    assign fin = ctl_dly_reg[TW];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg     <= 2'd0;
            seq_reg      <= 2'd0;
            result_valid <= 1'b0;
        end
        else
        begin
            if (accept)
                hold_reg <= 2'd2;
            else if (hold_reg != 2'd0)
                hold_reg <= hold_reg - 2'd1;
            result_valid <= 1'b0;
            if (dv_reg)
            begin
                result_valid <= 1'b1;
                seq_reg      <= fin.split ? 2'd2 : 2'd0;
            end
            else if (seq_reg != 2'd0)
            begin
                result_valid <= 1'b1;
                seq_reg      <= seq_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dv_reg)
        begin
            hc_reg  <= fin;
            hi1_reg <= i1;
            hi2_reg <= i2;
            if (fin.split)
            begin
                tri_out <= {fin.lone_side, 1'b0, fin.v0, i1, i2};
            end
            else
            begin
                tri_out <= {fin.whole_side, 1'b1, fin.v0, fin.v1, fin.v2};
            end
        end
        else if (seq_reg == 2'd2)
            tri_out <= {~hc_reg.lone_side, 1'b0, hc_reg.v1, hc_reg.v2, hi2_reg};
        else if (seq_reg == 2'd1)
            tri_out <= {~hc_reg.lone_side, 1'b1, hc_reg.v1, hi2_reg, hi1_reg};
    end

`ifndef SYNTHESIS
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n) dv1 == dv2)
        else $error("dividers out of step");
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        dv_reg |-> seq_reg == 2'd0)
        else $error("new triangle while sequencing");
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised");
`endif

endmodule

`default_nettype wire

// File: dv/testbench.sv
// testbench for triangle_plane_clipper: directed and random triangles under several planes
// depends on tpc_pkg and the clipper rtl; self-checking, predicts every result triangle
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tpc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 40;

    typedef logic signed [127:0] big_t;

    // expected result triangles and plane copy
    class clip_scoreboard;
        plane_t plane;
        tri_out_t pending[$];
        int errors;

        function new();
            plane = '0;
            plane.normal.z = coord_t'(1 << FB);
            errors = 0;
        endfunction

        function void report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h expected %h", what, got, want);
            errors++;
        endfunction

        function big_t distance_of(vec_t v);
            big_t s;
            s = (big_t'(v.x) - big_t'(plane.point.x)) * big_t'(plane.normal.x);
            s = s + (big_t'(v.y) - big_t'(plane.point.y)) * big_t'(plane.normal.y);
            s = s + (big_t'(v.z) - big_t'(plane.point.z)) * big_t'(plane.normal.z);
            return s;
        endfunction

        function coord_t lerp_axis(coord_t a, coord_t b, big_t t);
            big_t prod;
            prod = (big_t'(b) - big_t'(a)) * t;
            prod = prod >>> FB;
            prod = big_t'(a) + prod;
            return coord_t'(prod[CW-1:0]);
        endfunction

        // crossing on edge a-b from the two distances
        function vec_t crossing_of(vec_t a, vec_t b, big_t da, big_t db);
            logic [127:0] mag, num, den, q;
            vec_t r;
            mag = (da < 0) ? -da : da;
            den = mag + ((db < 0) ? -db : db);
            num = mag << FB;
            q = num / den;
            r.x = lerp_axis(a.x, b.x, big_t'(q));
            r.y = lerp_axis(a.y, b.y, big_t'(q));
            r.z = lerp_axis(a.z, b.z, big_t'(q));
            return r;
        endfunction

        function void push_tri(logic sd, logic lst, vec_t p, vec_t q, vec_t r);
            tri_out_t o;
            o.side = sd;
            o.last = lst;
            o.out0_x = p.x; o.out0_y = p.y; o.out0_z = p.z;
            o.out1_x = q.x; o.out1_y = q.y; o.out1_z = q.z;
            o.out2_x = r.x; o.out2_y = r.y; o.out2_z = r.z;
            pending = {pending, o};
        endfunction

        // accepted request: predict its result triangles
        function void note_request(tri_in_t t);
            vec_t v[3];
            big_t d[3];
            vec_t i1, i2;
            int above, lone, a1, a2;
            logic lone_side;
            v[0] = '{t.vertex0_x, t.vertex0_y, t.vertex0_z};
            v[1] = '{t.vertex1_x, t.vertex1_y, t.vertex1_z};
            v[2] = '{t.vertex2_x, t.vertex2_y, t.vertex2_z};
            above = 0;
            for (int k = 0; k < 3; k++)
            begin
                d[k] = distance_of(v[k]);
                if (d[k] >= 0)
                    above++;
            end
            if (above == 3 || above == 0)
            begin
                push_tri(above == 3, 1'b1, v[0], v[1], v[2]);
                return;
            end
            lone = 0;
            for (int k = 2; k >= 0; k--)
                if ((d[k] >= 0) == (above == 1))
                    lone = k;
            a1 = (lone + 1) % 3;
            a2 = (lone + 2) % 3;
            lone_side = (above == 1);
            i1 = crossing_of(v[lone], v[a1], d[lone], d[a1]);
            i2 = crossing_of(v[lone], v[a2], d[lone], d[a2]);
            push_tri(lone_side, 1'b0, v[lone], i1, i2);
            push_tri(!lone_side, 1'b0, v[a1], v[a2], i2);
            push_tri(!lone_side, 1'b1, v[a1], i2, i1);
        endfunction

        function void check_result(tri_out_t got);
            tri_out_t want;
            if (pending.size() == 0)
            begin
                report("unexpected result", 32'(got.side), 32'(got.last));
                return;
            end
            want = pending.pop_front();
            if (got.side !== want.side) report("side", 32'(got.side), 32'(want.side));
            if (got.last !== want.last) report("last", 32'(got.last), 32'(want.last));
            if (got.out0_x !== want.out0_x) report("out0_x", got.out0_x, want.out0_x);
            if (got.out0_y !== want.out0_y) report("out0_y", got.out0_y, want.out0_y);
            if (got.out0_z !== want.out0_z) report("out0_z", got.out0_z, want.out0_z);
            if (got.out1_x !== want.out1_x) report("out1_x", got.out1_x, want.out1_x);
            if (got.out1_y !== want.out1_y) report("out1_y", got.out1_y, want.out1_y);
            if (got.out1_z !== want.out1_z) report("out1_z", got.out1_z, want.out1_z);
            if (got.out2_x !== want.out2_x) report("out2_x", got.out2_x, want.out2_x);
            if (got.out2_y !== want.out2_y) report("out2_y", got.out2_y, want.out2_y);
            if (got.out2_z !== want.out2_z) report("out2_z", got.out2_z, want.out2_z);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    tri_in_t tri_in;
    logic result_valid;
    tri_out_t tri_out;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    logic [31:0] cfg_data;

    clip_scoreboard board = new();
    int cycles;
    bit allow_gaps;

    triangle_plane_clipper i_dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .tri_in(tri_in),
        .result_valid(result_valid),
        .tri_out(tri_out),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // result monitor and cycle limit
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            board.check_result(tri_out);
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // one register write; valid is left high for a following write
    task automatic write_reg(logic [2:0] idx, coord_t value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic load_plane(plane_t p);
        write_reg(REG_POINT_X, p.point.x);
        write_reg(REG_POINT_Y, p.point.y);
        write_reg(REG_POINT_Z, p.point.z);
        write_reg(REG_NORMAL_X, p.normal.x);
        write_reg(REG_NORMAL_Y, p.normal.y);
        write_reg(REG_NORMAL_Z, p.normal.z);
        cfg_valid <= 1'b0;
        board.plane = p;
    endtask

    // wait until every expected triangle is out and the pipe is empty
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one request; start stays high afterwards unless a gap follows
    task automatic send_tri(tri_in_t t);
        start <= 1'b1;
        tri_in <= t;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_request(t);
        if (allow_gaps && $urandom_range(3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge clk);
        end
    endtask

    function automatic coord_t pick_coord(coord_t center);
        case ($urandom_range(5))
            0: return coord_t'($urandom);
            1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
            2: return center + coord_t'($signed($urandom_range(2000)) - 1000);
            default: return center + coord_t'($signed($urandom_range(32'h0080_0000)) - 32'sh0040_0000);
        endcase
    endfunction

    function automatic tri_in_t random_tri(plane_t p);
        tri_in_t t;
        t.vertex0_x = pick_coord(p.point.x);
        t.vertex0_y = pick_coord(p.point.y);
        t.vertex0_z = pick_coord(p.point.z);
        t.vertex1_x = pick_coord(p.point.x);
        t.vertex1_y = pick_coord(p.point.y);
        t.vertex1_z = pick_coord(p.point.z);
        t.vertex2_x = pick_coord(p.point.x);
        t.vertex2_y = pick_coord(p.point.y);
        t.vertex2_z = pick_coord(p.point.z);
        return t;
    endfunction

    function automatic tri_in_t zs_tri(coord_t z0, coord_t z1, coord_t z2);
        tri_in_t t;
        t = random_tri(board.plane);
        t.vertex0_z = z0;
        t.vertex1_z = z1;
        t.vertex2_z = z2;
        return t;
    endfunction

    initial
    begin
        plane_t p;
        tri_in_t t;
        coord_t hi, lo, one;
        hi = 32'h7fff_ffff;
        lo = 32'h8000_0000;
        one = coord_t'(1 << FB);
        cycles = 0;
        allow_gaps = 1'b1;
        rst_n = 1'b0;
        start = 1'b0;
        tri_in = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_POINT_X;
        cfg_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset plane z >= 0 counts as above
        send_tri(zs_tri(one, 2 * one, 0));
        send_tri(zs_tri(-one, -5, lo));
        send_tri(zs_tri(hi, hi, hi));
        send_tri(zs_tri(lo, lo, lo));
        send_tri(zs_tri(one, -one, -one));
        send_tri(zs_tri(-one, one, -one));
        send_tri(zs_tri(-one, -one, one));
        send_tri(zs_tri(-one, one, one));
        send_tri(zs_tri(one, -one, one));
        send_tri(zs_tri(one, one, -one));
        send_tri(zs_tri(0, -1, -1));
        send_tri(zs_tri(-1, 0, 0));
        send_tri(zs_tri(hi, lo, lo));
        send_tri(zs_tri(lo, hi, hi));
        t = '{hi, lo, hi, lo, hi, lo, hi, lo, hi};
        send_tri(t);
        t = '{lo, hi, lo, hi, lo, hi, lo, hi, lo};
        send_tri(t);
        drain();

        // zero normal: every triangle passes as above
        p = '0;
        load_plane(p);
        send_tri(random_tri(p));
        send_tri(zs_tri(lo, -one, hi));
        drain();

        // extreme planes
        p.point = '{hi, hi, hi};
        p.normal = '{lo, lo, lo};
        load_plane(p);
        send_tri(zs_tri(lo, hi, lo));
        t = '{lo, lo, lo, hi, hi, hi, lo, hi, lo};
        send_tri(t);
        send_tri(random_tri(p));
        drain();
        p.point = '{lo, lo, lo};
        p.normal = '{hi, hi, hi};
        load_plane(p);
        t = '{hi, hi, hi, lo, lo, lo, hi, lo, hi};
        send_tri(t);
        send_tri(random_tri(p));
        drain();

        // random phases, each with its own plane
        for (int phase = 0; phase < 8; phase++)
        begin
            p.point = '{pick_coord(0), pick_coord(0), pick_coord(0)};
            case (phase % 3)
                0: p.normal = '{coord_t'($urandom), coord_t'($urandom), coord_t'($urandom)};
                1: p.normal = '{coord_t'($urandom_range(2 * one)) - one,
                                coord_t'($urandom_range(2 * one)) - one,
                                coord_t'($urandom_range(2 * one)) - one};
                default: p.normal = '{0, coord_t'($urandom_range(1) ? one : -one), 0};
            endcase
            load_plane(p);
            allow_gaps = (phase < 7);
            for (int n = 0; n < 48; n++)
            begin
                if (phase == 3 && n == 24)
                begin
                    start <= 1'b0;
                    @(posedge clk);
                    while (board.pending.size() != 0)
                        @(posedge clk);
                end
                send_tri(random_tri(p));
            end
            drain();
        end

        if (board.errors == 0 && board.pending.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
